// File: hw/rtl/spl_pkg.sv
// Package for the path loss block: formats, constants, coefficient tables and helpers.
package spl_pkg;

  // Field widths.
  localparam int DIST_W = 20;
  localparam int CFG_W  = 14;
  localparam int LOSS_W = 18;
  localparam int L2_W   = 21;   // unsigned log2 in Q16 of a value below 2^20
  localparam int M_W    = 31;   // normalized mantissa in Q30
  localparam int NSQ    = 16;   // fraction bits of log2

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_FREQ    = 2'd0;
  localparam logic [1:0] REG_TX_H    = 2'd1;
  localparam logic [1:0] REG_RX_H    = 2'd2;
  localparam logic [1:0] REG_TERRAIN = 2'd3;

  // Terrain codes.
  localparam logic [1:0] TERRAIN_SUBURBAN = 2'd2;
  localparam logic [1:0] TERRAIN_RURAL    = 2'd3;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] FREQ_RST    = 14'd2400;
  localparam logic [CFG_W-1:0] TX_H_RST    = 14'd480;
  localparam logic [CFG_W-1:0] RX_H_RST    = 14'd32;
  localparam logic [1:0]       TERRAIN_RST = 2'd1;

  // Fixed-point constants.
  localparam logic [28:0]        LOG10_2_Q30 = 29'd323228497;
  localparam logic signed [31:0] A_CONST_Q16 = 32'sd815383;
  localparam logic signed [31:0] FADE_Q16    = 32'sd537395;
  localparam logic [CFG_W-1:0]   FREQ_CORR_MIN = 14'd2000;
  localparam logic signed [27:0] LOSS_MIN = -28'sd65536;
  localparam logic signed [27:0] LOSS_MAX = 28'sd131071;

  // Configuration engine states.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_NORM,
    CS_SQ,
    CS_CONV,
    CS_DIV,
    CS_MUL,
    CS_SUM
  } cfg_state_t;

  // Exponent intercept a in Q20.
  function automatic logic signed [23:0] coef_a(input logic [1:0] tc);
    case (tc)
      TERRAIN_SUBURBAN: coef_a = 24'sd4194304;
      TERRAIN_RURAL:    coef_a = 24'sd3774874;
      default:          coef_a = 24'sd4823450;
    endcase
  endfunction

  // Exponent slope b in Q24.
  function automatic logic [16:0] coef_b(input logic [1:0] tc);
    case (tc)
      TERRAIN_SUBURBAN: coef_b = 17'd109052;
      TERRAIN_RURAL:    coef_b = 17'd83886;
      default:          coef_b = 17'd125829;
    endcase
  endfunction

  // Exponent term c in Q20, already scaled by 16 for heights in 1/16 m.
  function automatic logic [28:0] coef_c16(input logic [1:0] tc);
    case (tc)
      TERRAIN_SUBURBAN: coef_c16 = 29'd286890400;
      TERRAIN_RURAL:    coef_c16 = 29'd335544320;
      default:          coef_c16 = 29'd211392928;
    endcase
  endfunction

  // Receiver height correction factor in Q16.
  function automatic logic signed [21:0] coef_xh(input logic [1:0] tc);
    case (tc)
      TERRAIN_RURAL: coef_xh = -22'sd1310720;
      default:       coef_xh = -22'sd707789;
    endcase
  endfunction

  // Position of the most significant set bit; zero for inputs zero and one.
  function automatic logic [4:0] msb_pos(input logic [DIST_W-1:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < DIST_W; i++) begin
      if (x[i]) n = 5'(i);
    end
    return n;
  endfunction

  // Mantissa aligned so that its leading one sits at bit 30.
  function automatic logic [M_W-1:0] norm_mant(input logic [DIST_W-1:0] x,
                                               input logic [4:0] n);
    logic [M_W-1:0] xe;
    xe = M_W'(x);
    return xe << (5'd30 - n);
  endfunction

  // One squaring step of the log2 fraction: {result bit, next mantissa}.
  function automatic logic [M_W:0] sq_step(input logic [M_W-1:0] m);
    logic [2*M_W-1:0] p;
    p = m * m;
    if (p[61]) return {1'b1, p[61:31]};
    return {1'b0, p[60:30]};
  endfunction

  // Arithmetic right shift with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< (s - 1)) - (v[63] ? 64'sd1 : 64'sd0);
    return (v + bias) >>> s;
  endfunction

endpackage

// File: hw/rtl/sui_path_loss.sv
// Top level of the path loss block: configuration engine and per-distance pipeline.
//
// Usage:
// - Configuration: cfg_valid/cfg_ready with cfg_index (0 frequency, 1 transmitter
//   height, 2 receiver height, 3 terrain class) and cfg_data. A transfer takes place
//   when both are high. Each transfer starts a recomputation of the terms that
//   depend only on configuration; busy and a low cfg_ready cover it.
// - Input: a distance is taken at a rising edge where start is high and busy is low.
//   One distance can be taken in every cycle while busy is low.
// - Output: out_valid is high for one cycle with out_loss_q8 and out_clipped.
//   Results appear in the order in which their distances were taken.
//   The receiver cannot stall, and the pipeline never holds or drops an item.
// - The pipeline is made of the sixteen squaring stages of the log2 unit (one 31x31
//   multiply each) followed by the log10 scaling, exponent multiply, rounding,
//   constant add and saturation stages.
// - Reset loads the default registers and runs the recomputation; busy
//   stays high until it ends.
// - The user writes configuration only while no distance is in flight; the block does not enforce it.
module sui_path_loss
  import spl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [DIST_W-1:0]        in_distance_m,
  output logic                     out_valid,
  output logic signed [LOSS_W-1:0] out_loss_q8,
  output logic                     out_clipped,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  // Configuration registers.
  logic [CFG_W-1:0] freq_r, tx_h_r, rx_h_r;
  logic [1:0]       terrain_r;
  logic             cfg_xfer;

  assign cfg_xfer = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r    <= FREQ_RST;
      tx_h_r    <= TX_H_RST;
      rx_h_r    <= RX_H_RST;
      terrain_r <= TERRAIN_RST;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_FREQ:    freq_r    <= cfg_data;
        REG_TX_H:    tx_h_r    <= cfg_data;
        REG_RX_H:    rx_h_r    <= cfg_data;
        REG_TERRAIN: terrain_r <= cfg_data[1:0];
        default:     freq_r    <= freq_r;
      endcase
    end
  end

  // Zero values count as one.
  logic [CFG_W-1:0] f_v, ht_v, hr_v;
  assign f_v  = (freq_r == '0) ? CFG_W'(1) : freq_r;
  assign ht_v = (tx_h_r == '0) ? CFG_W'(1) : tx_h_r;
  assign hr_v = (rx_h_r == '0) ? CFG_W'(1) : rx_h_r;

  // Configuration engine state.
  cfg_state_t cstate_r, cstate_nxt;
  logic [4:0] cnt_r;
  logic       phase_r;

  always_comb begin
    cstate_nxt = cstate_r;
    case (cstate_r)
      CS_IDLE: if (cfg_xfer) cstate_nxt = CS_NORM;
      CS_NORM: cstate_nxt = CS_SQ;
      CS_SQ:   if (cnt_r == '0) cstate_nxt = phase_r ? CS_CONV : CS_NORM;
      CS_CONV: if (cnt_r == 5'd2) cstate_nxt = CS_DIV;
      CS_DIV:  if (cnt_r == '0) cstate_nxt = CS_MUL;
      CS_MUL:  cstate_nxt = CS_SUM;
      CS_SUM:  cstate_nxt = CS_IDLE;
      default: cstate_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    busy      = (cstate_r != CS_IDLE);
    cfg_ready = (cstate_r == CS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cstate_r <= CS_NORM;
    else        cstate_r <= cstate_nxt;
  end

  // Engine datapath: serial log2, log10 conversions, divider and final sums.
  logic [M_W-1:0]          me_r;
  logic [L2_W-1:0]         re_r, lf2_r, lh2_r;
  logic signed [19:0]      l0_r, l1_r, l2_r;
  logic [14:0]             rem_r;
  logic [28:0]             num_r;
  logic [30:0]             pb_r;
  logic signed [41:0]      px_r;
  logic signed [33:0]      y10_r;
  logic signed [31:0]      k_r;

  logic [CFG_W-1:0]        op_v;
  logic [4:0]              op_n;
  logic [M_W:0]            sq_e;
  logic [L2_W-1:0]         re_upd;
  logic signed [21:0]      conv_in;
  logic signed [50:0]      conv_p;
  logic signed [19:0]      conv_out;
  logic [14:0]             div_trial;
  logic                    div_ge;
  logic signed [63:0]      y_full, k_full;

  always_comb begin
    op_v   = phase_r ? hr_v : f_v;
    op_n   = msb_pos(DIST_W'(op_v));
    sq_e   = sq_step(me_r);
    re_upd = re_r | (L2_W'(sq_e[M_W]) << cnt_r[3:0]);
    case (cnt_r[1:0])
      2'd0:    conv_in = $signed({1'b0, lf2_r});
      2'd1:    conv_in = $signed({1'b0, lf2_r}) - 22'sd65536;
      default: conv_in = $signed({1'b0, lh2_r}) - 22'sd327680;
    endcase
    conv_p    = conv_in * $signed({1'b0, LOG10_2_Q30});
    conv_out  = 20'(rnd_shift(64'(conv_p), 30));
    div_trial = {rem_r[13:0], num_r[28]};
    div_ge    = (div_trial >= {1'b0, ht_v});
    y_full   = 64'(coef_a(terrain_r)) - rnd_shift(64'($signed({1'b0, pb_r})), 8)
             + 64'($signed({1'b0, num_r}));
    k_full   = 64'(l0_r) * 64'sd20 + 64'(A_CONST_Q16) + 64'(FADE_Q16);
    if (f_v > FREQ_CORR_MIN) begin
      k_full = k_full + 64'(l1_r) * 64'sd6 + rnd_shift(64'(px_r), 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      case (cstate_r)
        CS_IDLE: begin
          cnt_r   <= '0;
          phase_r <= 1'b0;
        end
        CS_NORM: cnt_r <= 5'd15;
        CS_SQ: begin
          if (cnt_r == '0) phase_r <= 1'b1;
          else             cnt_r   <= cnt_r - 5'd1;
        end
        CS_CONV: cnt_r <= (cnt_r == 5'd2) ? 5'd28 : cnt_r + 5'd1;
        CS_DIV:  if (cnt_r != '0) cnt_r <= cnt_r - 5'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cstate_r)
      CS_NORM: begin
        me_r <= norm_mant(DIST_W'(op_v), op_n);
        re_r <= L2_W'({op_n, 16'b0});
      end
      CS_SQ: begin
        me_r <= sq_e[M_W-1:0];
        re_r <= re_upd;
        if (cnt_r == '0) begin
          if (phase_r) lh2_r <= re_upd;
          else         lf2_r <= re_upd;
        end
      end
      CS_CONV: begin
        case (cnt_r[1:0])
          2'd0:    l0_r <= conv_out;
          2'd1:    l1_r <= conv_out;
          default: l2_r <= conv_out;
        endcase
        if (cnt_r == 5'd2) begin
          num_r <= coef_c16(terrain_r) + 29'(ht_v >> 1);
          rem_r <= '0;
        end
      end
      CS_DIV: begin
        rem_r <= div_ge ? div_trial - {1'b0, ht_v} : div_trial;
        num_r <= {num_r[27:0], div_ge};
      end
      CS_MUL: begin
        pb_r <= coef_b(terrain_r) * ht_v;
        px_r <= coef_xh(terrain_r) * l2_r;
      end
      CS_SUM: begin
        y10_r <= 34'(y_full * 64'sd10);
        k_r   <= 32'(k_full);
      end
      default: me_r <= me_r;
    endcase
  end

  // Item pipeline: normalize at the input, then one squaring per stage.
  logic                  sv_r [0:NSQ];
  logic [M_W-1:0]        sm_r [0:NSQ];
  logic [L2_W-1:0]       sr_r [0:NSQ];
  logic [4:0]            in_n;
  logic                  in_xfer;
  logic [DIST_W-1:0]     in_d;

  assign in_xfer = start && !busy;
  assign in_d    = (in_distance_m == '0) ? DIST_W'(1) : in_distance_m;
  assign in_n    = msb_pos(in_d);

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else        sv_r[0] <= in_xfer;
    sm_r[0] <= norm_mant(in_d, in_n);
    sr_r[0] <= L2_W'({in_n, 16'b0});
  end

  for (genvar k = 1; k <= NSQ; k++) begin : g_sq
    logic [M_W:0] st;
    assign st = sq_step(sm_r[k-1]);
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k] <= 1'b0;
      else        sv_r[k] <= sv_r[k-1];
      sm_r[k] <= st[M_W-1:0];
      sr_r[k] <= sr_r[k-1] | (L2_W'(st[M_W]) << (NSQ - k));
    end
  end

  // Back end: log10 scaling, exponent product, rounding, sum, saturation.
  logic               v17_r, v18_r, v19_r, v20_r, v21_r;
  logic [49:0]        p17_r;
  logic signed [19:0] ld18_r;
  logic signed [53:0] p19_r;
  logic signed [33:0] t20_r;
  logic signed [35:0] tot21_r;

  logic [49:0]        p17_nxt;
  logic [20:0]        l10_v;
  logic signed [27:0] q8_v;

  always_comb begin
    p17_nxt = sr_r[NSQ] * LOG10_2_Q30;
    l10_v   = 21'((p17_r + 50'd536870912) >> 30);
    q8_v    = 28'(rnd_shift(64'(tot21_r), 8));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v17_r     <= 1'b0;
      v18_r     <= 1'b0;
      v19_r     <= 1'b0;
      v20_r     <= 1'b0;
      v21_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v17_r     <= sv_r[NSQ];
      v18_r     <= v17_r;
      v19_r     <= v18_r;
      v20_r     <= v19_r;
      v21_r     <= v20_r;
      out_valid <= v21_r;
    end
    p17_r   <= p17_nxt;
    ld18_r  <= $signed(l10_v[19:0]) - 20'sd131072;
    p19_r   <= y10_r * ld18_r;
    t20_r   <= 34'(rnd_shift(64'(p19_r), 20));
    tot21_r <= 36'(t20_r) + 36'(k_r);
    if (q8_v < LOSS_MIN) begin
      out_loss_q8 <= LOSS_W'(LOSS_MIN);
      out_clipped <= 1'b1;
    end else if (q8_v > LOSS_MAX) begin
      out_loss_q8 <= LOSS_W'(LOSS_MAX);
      out_clipped <= 1'b1;
    end else begin
      out_loss_q8 <= q8_v[LOSS_W-1:0];
      out_clipped <= 1'b0;
    end
  end

endmodule

// File: test/tb.sv
// Self-checking testbench for the path loss block: directed table, then randomized phases.
module tb;
  import spl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [DIST_W-1:0]        in_distance_m;
  logic                     out_valid;
  logic signed [LOSS_W-1:0] out_loss_q8;
  logic                     out_clipped;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  typedef struct {
    logic signed [LOSS_W-1:0] loss;
    logic                     clip;
  } loss_t;

  typedef struct {
    logic [CFG_W-1:0]         freq;
    logic [CFG_W-1:0]         tx_h;
    logic [CFG_W-1:0]         rx_h;
    logic [1:0]               terrain;
    logic [DIST_W-1:0]        distance;
    bit                       known;
    logic signed [LOSS_W-1:0] loss;
    logic                     clip;
  } row_t;

  // Mirror of the configuration registers.
  logic [CFG_W-1:0] cur_freq, cur_tx_h, cur_rx_h;
  logic [1:0]       cur_terrain;

  loss_t pending_losses[$];
  int    fail_count;

  sui_path_loss dut (.*);

  // Clock.
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Rounding shift, half away from zero.
  function automatic longint round_sh(longint v, int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  // Log2 in Q16 by repeated squaring of the Q30 mantissa.
  function automatic longint log2_fix(longint unsigned x);
    int unsigned   n;
    longint unsigned m;
    longint        r;
    n = 0;
    if (x == 0) x = 1;
    while (n < 30 && (x >> (n + 1)) != 0) n++;
    m = x << (30 - n);
    r = longint'(n) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r += 64'sd1 << i;
      end
    end
    return r;
  endfunction

  function automatic longint log10_fix(longint l2);
    return round_sh(l2 * 64'sd323228497, 30);
  endfunction

  // Expected loss for one distance under the current register settings.
  function automatic loss_t predict_loss(logic [DIST_W-1:0] d);
    longint a_tab[3]  = '{4823450, 4194304, 3774874};
    longint b_tab[3]  = '{125829, 109052, 83886};
    longint c_tab[3]  = '{13212058, 17930650, 20971520};
    longint xh_tab[3] = '{-707789, -707789, -1310720};
    longint f, ht, hr, y, ld, total, q8;
    int     k;
    loss_t  res;
    f  = (cur_freq == 0) ? 1 : cur_freq;
    ht = (cur_tx_h == 0) ? 1 : cur_tx_h;
    hr = (cur_rx_h == 0) ? 1 : cur_rx_h;
    k  = (cur_terrain == TERRAIN_SUBURBAN) ? 1 : (cur_terrain == TERRAIN_RURAL) ? 2 : 0;
    y = a_tab[k] - round_sh(b_tab[k] * ht, 8) + (c_tab[k] * 16 + ht / 2) / ht;
    ld = log10_fix(log2_fix(d)) - (64'sd2 <<< 16);
    total = 20 * log10_fix(log2_fix(f)) + 815383;
    total += round_sh(10 * y * ld, 20);
    // Frequency and receiver-height corrections apply only above 2000 MHz.
    if (f > 2000) begin
      total += 6 * log10_fix(log2_fix(f) - (64'sd1 <<< 16));
      total += round_sh(xh_tab[k] * log10_fix(log2_fix(hr) - (64'sd5 <<< 16)), 16);
    end
    total += 537395;
    q8 = round_sh(total, 8);
    res.clip = 1'b0;
    if (q8 < -65536) begin
      q8 = -65536;
      res.clip = 1'b1;
    end else if (q8 > 131071) begin
      q8 = 131071;
      res.clip = 1'b1;
    end
    res.loss = LOSS_W'(q8);
    return res;
  endfunction

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    loss_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_losses.size() == 0) begin
        $error("unexpected result: loss_q8=%0d clipped=%0d", out_loss_q8, out_clipped);
        fail_count++;
      end else begin
        exp_r = pending_losses.pop_front();
        if (out_loss_q8 !== exp_r.loss) begin
          $error("loss_q8 expected %0d got %0d", exp_r.loss, out_loss_q8);
          fail_count++;
        end
        if (out_clipped !== exp_r.clip) begin
          $error("clipped expected %0d got %0d", exp_r.clip, out_clipped);
          fail_count++;
        end
      end
    end
  end

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_losses.size() != 0) @(posedge clk);
  endtask

  // One register transfer, made only while no distance is in flight.
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    drain_results();
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FREQ:    cur_freq    = val;
      REG_TX_H:    cur_tx_h    = val;
      REG_RX_H:    cur_rx_h    = val;
      REG_TERRAIN: cur_terrain = val[1:0];
      default:     cur_freq    = cur_freq;
    endcase
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] f, logic [CFG_W-1:0] tx,
                                logic [CFG_W-1:0] rx, logic [1:0] tc);
    if (f != cur_freq)     write_reg(REG_FREQ, f);
    if (tx != cur_tx_h)    write_reg(REG_TX_H, tx);
    if (rx != cur_rx_h)    write_reg(REG_RX_H, rx);
    if (tc != cur_terrain) write_reg(REG_TERRAIN, CFG_W'(tc));
  endtask

  // Send one distance; the expectation is recorded at the accepting edge.
  // Each following cycle is left idle with the given percentage.
  task automatic send_distance(logic [DIST_W-1:0] d, int gap_pct, bit known,
                               loss_t typed);
    start         <= 1'b1;
    in_distance_m <= d;
    do @(posedge clk); while (busy);
    pending_losses.push_back(known ? typed : predict_loss(d));
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [DIST_W-1:0] rand_distance();
    int sh;
    case ($urandom_range(3))
      0: return DIST_W'($urandom_range(1, 1048575));
      1: return DIST_W'($urandom_range(1, 5000));
      2: begin
        sh = $urandom_range(19);
        return DIST_W'((1 << sh) + $urandom_range(2) - 1);
      end
      default: return DIST_W'($urandom_range(50, 200));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg();
    case ($urandom_range(5))
      0: return CFG_W'(1);
      1: return CFG_W'(16383);
      2: return CFG_W'($urandom_range(1, 64));
      default: return CFG_W'($urandom_range(1, 16383));
    endcase
  endfunction

  // Directed cases: reset settings, distance and setting extremes, each terrain,
  // both sides of the 2000 MHz corner, zero values and both saturation limits.
  row_t dir_rows[] = '{
    '{2400, 480, 32, 1, 1, 0, 0, 0},
    '{2400, 480, 32, 1, 1048575, 0, 0, 0},
    '{2400, 480, 32, 1, 0, 0, 0, 0},
    '{2400, 480, 32, 1, 100, 0, 0, 0},
    '{2400, 480, 32, 1, 1000, 0, 0, 0},
    '{2400, 480, 32, 2, 1000, 0, 0, 0},
    '{2400, 480, 32, 3, 1000, 0, 0, 0},
    '{2400, 480, 32, 0, 1000, 0, 0, 0},
    '{2000, 480, 32, 1, 1000, 0, 0, 0},
    '{2001, 480, 32, 1, 1000, 0, 0, 0},
    '{16383, 480, 32, 1, 1000, 0, 0, 0},
    '{1, 480, 32, 1, 1000, 0, 0, 0},
    '{0, 480, 32, 1, 1000, 0, 0, 0},
    '{2400, 480, 1, 1, 1000, 0, 0, 0},
    '{2400, 480, 16383, 3, 1000, 0, 0, 0},
    '{2400, 480, 0, 1, 1000, 0, 0, 0},
    '{2400, 16383, 32, 1, 1048575, 0, 0, 0},
    '{2400, 0, 32, 1, 500, 0, 0, 0},
    '{2400, 1, 32, 1, 1048575, 1, 131071, 1},
    '{2400, 1, 32, 1, 1, 1, -65536, 1}
  };

  int phase_gap[4] = '{0, 83, 0, 30};

  // Stimulus.
  initial begin
    loss_t typed;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_distance_m = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_FREQ;
    cfg_data      = '0;
    fail_count    = 0;
    cur_freq      = FREQ_RST;
    cur_tx_h      = TX_H_RST;
    cur_rx_h      = RX_H_RST;
    cur_terrain   = TERRAIN_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      apply_settings(dir_rows[i].freq, dir_rows[i].tx_h, dir_rows[i].rx_h,
                     dir_rows[i].terrain);
      typed.loss = dir_rows[i].loss;
      typed.clip = dir_rows[i].clip;
      send_distance(dir_rows[i].distance, 0, dir_rows[i].known, typed);
    end

    // Random phases, each with fresh settings and the idle percentage from phase_gap.
    for (int p = 0; p < 4; p++) begin
      apply_settings(rand_reg(), rand_reg(), rand_reg(), 2'($urandom_range(3)));
      for (int n = 0; n < 160; n++) begin
        send_distance(rand_distance(), phase_gap[p], 0, typed);
        // Hold off once mid-phase until the pipeline is empty.
        if (p == 2 && n == 80) drain_results();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/spl_pkg.sv
hw/rtl/sui_path_loss.sv
test/tb.sv
